// ===== hw/rtl/pca_pkg.sv =====
// Shared types and constants of the polygon centroid accumulator.
`default_nettype none

package pca_pkg;

	localparam int COORD_BITS = 16;
	localparam int CENT_BITS = 24;
	localparam int AREA_OUT_BITS = 43;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	localparam int STEP_W = $clog2(CENT_BITS + 1);

	localparam logic [CENT_BITS-1:0] CENT_MIN_CODE = {1'b1, {(CENT_BITS-1){1'b0}}};
	localparam logic [CENT_BITS-1:0] CENT_MAX_CODE = {1'b0, {(CENT_BITS-1){1'b1}}};
	localparam logic signed [63:0] CENT_HI = (64'sd1 <<< (CENT_BITS - 1)) - 64'sd1;
	localparam logic signed [63:0] CENT_LO = -(64'sd1 <<< (CENT_BITS - 1));

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_DONE
	} pca_back_state_t;

	typedef struct packed {
		logic                  empty;
		logic                  full;
		logic [FIFO_CNT_W-1:0] count;
	} pca_fifo_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pca_vertex_if.sv =====
// Vertex channel: one polygon vertex per item.
`default_nettype none

interface pca_vertex_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [pca_pkg::COORD_BITS-1:0] vertex_x;
	logic signed [pca_pkg::COORD_BITS-1:0] vertex_y;
	logic                                  is_last;

	modport source (output valid, output vertex_x, output vertex_y, output is_last,
		input ready);
	modport sink (input valid, input vertex_x, input vertex_y, input is_last,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pca_result_if.sv =====
// Result channel: area and centroid of one closed polygon per item.
`default_nettype none

interface pca_result_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [pca_pkg::CENT_BITS-1:0]     centroid_x;
	logic signed [pca_pkg::CENT_BITS-1:0]     centroid_y;
	logic signed [pca_pkg::AREA_OUT_BITS-1:0] doubled_area;
	logic                                     degenerate;
	logic                                     too_many_vertices;

	modport source (output valid, output centroid_x, output centroid_y,
		output doubled_area, output degenerate, output too_many_vertices, input ready);
	modport sink (input valid, input centroid_x, input centroid_y,
		input doubled_area, input degenerate, input too_many_vertices, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/polygon_centroid_accumulator.sv =====
// Streaming shoelace area and centroid of polygons given vertex by vertex.
//
// The vertex channel takes one vertex per item with is_last on the final
// vertex of each polygon. Ordinary vertices are taken at one per cycle; a
// vertex with is_last holds ready low until the closing edge back to the
// first vertex, once the queue has room, enters the three-stage edge pipeline.
// Each closed polygon leaves a summary in a four-entry queue. The back end
// divides the weighted sums by three times the doubled area with a restoring
// divider, 24 steps per polygon (x and y in parallel); that divider loop
// bounds the rate for short polygons. A result passes through the edge
// pipeline, the queue, the divider and the output register after its last
// vertex is accepted. A stalled result channel holds the output register;
// the divider then waits, the queue fills, and finally the vertex channel
// drops ready on the next closing edge. Reset empties the queue, clears the
// sums and vertex count and drops the result valid; no clearing pass is run.
`default_nettype none

module polygon_centroid_accumulator #(
	parameter int MAX_VERTICES = 1024,
	parameter int FRAC_BITS = 8
) (
	input  wire           clk,
	input  wire           arst_n,
	pca_vertex_if.sink    vertex,
	pca_result_if.source  result
);

	localparam int CB = pca_pkg::COORD_BITS;
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int AREA_W = 2 * CB + CNT_W;
	localparam int WSUM_RAW = 3 * CB + CNT_W;
	localparam int WSUM_W = (WSUM_RAW > 64) ? 64 : WSUM_RAW;
	localparam int ENTRY_W = AREA_W + 2 * WSUM_W + 2 * (CB + 1) + 1;

	logic                       fifo_push, fifo_pop;
	logic [ENTRY_W-1:0]         fifo_wdata, fifo_rdata;
	pca_pkg::pca_fifo_status_t  fifo_stat;

	pca_front #(
		.MAX_VERTICES (MAX_VERTICES),
		.AREA_W       (AREA_W),
		.WSUM_W       (WSUM_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.vertex    (vertex),
		.fifo_stat (fifo_stat),
		.push      (fifo_push),
		.push_data (fifo_wdata)
	);

	pca_fifo #(.WIDTH(ENTRY_W)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fifo_push),
		.wr_data (fifo_wdata),
		.pop     (fifo_pop),
		.rd_data (fifo_rdata),
		.status  (fifo_stat)
	);

	pca_back #(
		.AREA_W    (AREA_W),
		.WSUM_W    (WSUM_W),
		.FRAC_BITS (FRAC_BITS),
		.ENTRY_W   (ENTRY_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_data   (fifo_rdata),
		.fifo_stat (fifo_stat),
		.pop       (fifo_pop),
		.result    (result)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/pca_front.sv =====
// Front end: classifies vertices, runs the edge pipeline and accumulates the sums.
`default_nettype none

module pca_front #(
	parameter int MAX_VERTICES = 1024,
	parameter int AREA_W = 43,
	parameter int WSUM_W = 59
) (
	input  wire                              clk,
	input  wire                              arst_n,
	pca_vertex_if.sink                       vertex,
	input  pca_pkg::pca_fifo_status_t        fifo_stat,
	output logic                             push,
	output logic [AREA_W+2*WSUM_W+2*(pca_pkg::COORD_BITS+1):0] push_data
);

	localparam int CB = pca_pkg::COORD_BITS;
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int FC_W = pca_pkg::FIFO_CNT_W + 1;

	logic signed [CB-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [CNT_W-1:0]     count_q;
	logic                 ovf_q;
	logic                 close_pend_q;

	logic accept, is_first, has_room, room_ok;
	logic [1:0] inflight;

	logic                 edge_v, edge_close;
	logic signed [CB-1:0] eax, eay, ebx, eby;

	logic                 v_s1, close_s1, ovf_s1;
	logic signed [CB-1:0] ax_s1, ay_s1, bx_s1, by_s1;

	logic                     v_s2, close_s2, ovf_s2;
	logic signed [2*CB-1:0]   p1_s2, p2_s2, p3_s2, p4_s2;
	logic signed [CB:0]       sx_s2, sy_s2;

	logic                     v_s3, close_s3, ovf_s3;
	logic signed [2*CB:0]     c_s3;
	logic signed [3*CB+1:0]   wx_s3, wy_s3;
	logic signed [CB:0]       sx_s3, sy_s3;

	logic signed [2*CB:0]     c_w;
	logic signed [AREA_W-1:0] area_q, area_next;
	logic signed [WSUM_W-1:0] wx_q, wy_q, wx_next, wy_next;

	assign vertex.ready = !close_pend_q;
	assign accept = vertex.valid && vertex.ready;
	assign is_first = (count_q == '0);
	assign has_room = (count_q < CNT_W'(MAX_VERTICES));

	// Closing edges already in the pipeline each need a queue slot when they arrive.
	assign inflight = {1'b0, v_s1 & close_s1} + {1'b0, v_s2 & close_s2}
		+ {1'b0, v_s3 & close_s3};
	assign room_ok = ({1'b0, fifo_stat.count} + {{(FC_W-2){1'b0}}, inflight})
		< FC_W'(pca_pkg::FIFO_DEPTH);

	always_comb begin
		edge_v = 1'b0;
		edge_close = 1'b0;
		eax = prev_x_q;
		eay = prev_y_q;
		ebx = vertex.vertex_x;
		eby = vertex.vertex_y;
		if (close_pend_q) begin
			edge_v = room_ok;
			edge_close = 1'b1;
			ebx = first_x_q;
			eby = first_y_q;
		end else if (accept && !is_first && has_room) begin
			edge_v = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q <= 1'b0;
			close_pend_q <= 1'b0;
		end else begin
			if (close_pend_q) begin
				if (room_ok) begin
					close_pend_q <= 1'b0;
					count_q <= '0;
					ovf_q <= 1'b0;
				end
			end else if (accept) begin
				if (is_first) begin
					count_q <= CNT_W'(1);
				end else if (has_room) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
				close_pend_q <= vertex.is_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!close_pend_q && accept) begin
			if (is_first) begin
				first_x_q <= vertex.vertex_x;
				first_y_q <= vertex.vertex_y;
				prev_x_q <= vertex.vertex_x;
				prev_y_q <= vertex.vertex_y;
			end else if (has_room) begin
				prev_x_q <= vertex.vertex_x;
				prev_y_q <= vertex.vertex_y;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= edge_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign c_w = (2*CB+1)'(p1_s2) - (2*CB+1)'(p2_s2);

	always_ff @(posedge clk) begin
		close_s1 <= edge_close;
		ovf_s1 <= ovf_q;
		ax_s1 <= eax;
		ay_s1 <= eay;
		bx_s1 <= ebx;
		by_s1 <= eby;

		close_s2 <= close_s1;
		ovf_s2 <= ovf_s1;
		p1_s2 <= ax_s1 * by_s1;
		p2_s2 <= bx_s1 * ay_s1;
		sx_s2 <= (CB+1)'(ax_s1) + (CB+1)'(bx_s1);
		sy_s2 <= (CB+1)'(ay_s1) + (CB+1)'(by_s1);

		close_s3 <= close_s2;
		ovf_s3 <= ovf_s2;
		c_s3 <= c_w;
		wx_s3 <= sx_s2 * c_w;
		wy_s3 <= sy_s2 * c_w;
		sx_s3 <= sx_s2;
		sy_s3 <= sy_s2;
	end

	assign area_next = area_q + AREA_W'(c_s3);
	assign wx_next = wx_q + WSUM_W'(wx_s3);
	assign wy_next = wy_q + WSUM_W'(wy_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q <= '0;
			wx_q <= '0;
			wy_q <= '0;
		end else if (v_s3) begin
			if (close_s3) begin
				area_q <= '0;
				wx_q <= '0;
				wy_q <= '0;
			end else begin
				area_q <= area_next;
				wx_q <= wx_next;
				wy_q <= wy_next;
			end
		end
	end

	// For the closing edge the endpoint sums are first plus last vertex.
	assign push = v_s3 && close_s3;
	assign push_data = {ovf_s3, sy_s3, sx_s3, wy_next, wx_next, area_next};

`ifndef SYNTH
	a_push_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_stat.full)
		else $error("polygon summary pushed into a full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_VERTICES))
		else $error("vertex count beyond the built maximum");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/pca_fifo.sv =====
// Short queue of polygon summaries between the front and the back end.
`default_nettype none

module pca_fifo #(
	parameter int WIDTH = 196
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        push,
	input  wire  [WIDTH-1:0]           wr_data,
	input  wire                        pop,
	output logic [WIDTH-1:0]           rd_data,
	output pca_pkg::pca_fifo_status_t  status
);

	localparam int PTR_W = pca_pkg::FIFO_PTR_W;
	localparam int CNT_W = pca_pkg::FIFO_CNT_W;
	localparam int DEPTH = pca_pkg::FIFO_DEPTH;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign rd_data = mem_q[rd_ptr_q];
	assign status.empty = (count_q == '0);
	assign status.full = (count_q == CNT_W'(DEPTH));
	assign status.count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

`ifndef SYNTH
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("summary queue read while empty");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/pca_div.sv =====
// Restoring divider lane: one quotient bit per step, magnitude in and out.
`default_nettype none

module pca_div #(
	parameter int NUM_W = 67,
	parameter int DEN_W = 44
) (
	input  wire                               clk,
	input  wire                               start,
	input  wire                               step,
	input  wire  [NUM_W-1:0]                  num,
	input  wire  [DEN_W-1:0]                  den,
	output logic [pca_pkg::CENT_BITS-1:0]     quot
);

	localparam int QB = pca_pkg::CENT_BITS;
	localparam int SHIFT_W = DEN_W + QB - 1;
	localparam int CMP_W = (NUM_W > SHIFT_W) ? NUM_W : SHIFT_W;

	logic [CMP_W-1:0] r_q, d_q;
	logic [QB-1:0]    q_q;
	logic             ge;

	assign ge = (r_q >= d_q);
	assign quot = q_q;

	// The first step tests the top quotient bit; a one there means saturation.
	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= CMP_W'(num);
			d_q <= CMP_W'(den) << (QB - 1);
			q_q <= '0;
		end else if (step) begin
			if (ge) begin
				r_q <= r_q - d_q;
			end
			d_q <= d_q >> 1;
			q_q <= {q_q[QB-2:0], ge};
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pca_back.sv =====
// Back end: turns a polygon summary into the fixed-point centroid and the result item.
`default_nettype none

module pca_back #(
	parameter int AREA_W = 43,
	parameter int WSUM_W = 59,
	parameter int FRAC_BITS = 8,
	parameter int ENTRY_W = 196
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire  [ENTRY_W-1:0]          rd_data,
	input  pca_pkg::pca_fifo_status_t   fifo_stat,
	output logic                        pop,
	pca_result_if.source                result
);

	localparam int CB = pca_pkg::COORD_BITS;
	localparam int QB = pca_pkg::CENT_BITS;
	localparam int STEP_W = pca_pkg::STEP_W;
	localparam int NUM_W = WSUM_W + FRAC_BITS;
	localparam int DEN_W = AREA_W + 1;
	localparam int MID_W = CB + 1 + FRAC_BITS;

	pca_pkg::pca_back_state_t state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic step, load_out;
	logic res_valid_q;

	logic signed [AREA_W-1:0] area_in;
	logic signed [WSUM_W-1:0] wx_in, wy_in;
	logic signed [CB:0]       sx_in, sy_in;
	logic                     ovf_in;
	logic [AREA_W-1:0]        area_mag;
	logic [WSUM_W-1:0]        wx_mag, wy_mag;
	logic [DEN_W-1:0]         den;
	logic [QB-1:0]            qx, qy;

	logic signed [AREA_W-1:0] area_q;
	logic                     negx_q, negy_q, degen_q, ovf_q;
	logic [QB-1:0]            midx_q, midy_q;

	logic [QB-1:0]            cx_q, cy_q;
	logic [pca_pkg::AREA_OUT_BITS-1:0] da_q;
	logic                     degen_out_q, ovf_out_q;
	logic signed [63:0]       area_ext;

	function automatic logic [QB-1:0] mid_fix(input logic signed [CB:0] s);
		logic signed [MID_W-1:0] v;
		logic signed [MID_W-1:0] h;
		logic signed [63:0]      h64;
		v = MID_W'(s) <<< FRAC_BITS;
		// Halving is to round toward zero, so a negative value is bumped by one first.
		h = v + $signed(MID_W'(v[MID_W-1]));
		h = h >>> 1;
		h64 = 64'(h);
		if (h64 > pca_pkg::CENT_HI) begin
			return pca_pkg::CENT_MAX_CODE;
		end else if (h64 < pca_pkg::CENT_LO) begin
			return pca_pkg::CENT_MIN_CODE;
		end
		return h64[QB-1:0];
	endfunction

	function automatic logic [QB-1:0] quot_fix(input logic [QB-1:0] q, input logic neg);
		if (neg) begin
			return q[QB-1] ? pca_pkg::CENT_MIN_CODE : QB'(-q);
		end
		return q[QB-1] ? pca_pkg::CENT_MAX_CODE : q;
	endfunction

	assign area_in = rd_data[AREA_W-1:0];
	assign wx_in = rd_data[AREA_W +: WSUM_W];
	assign wy_in = rd_data[AREA_W+WSUM_W +: WSUM_W];
	assign sx_in = rd_data[AREA_W+2*WSUM_W +: CB+1];
	assign sy_in = rd_data[AREA_W+2*WSUM_W+CB+1 +: CB+1];
	assign ovf_in = rd_data[ENTRY_W-1];

	assign area_mag = area_in[AREA_W-1] ? AREA_W'(-area_in) : area_in;
	assign wx_mag = wx_in[WSUM_W-1] ? WSUM_W'(-wx_in) : wx_in;
	assign wy_mag = wy_in[WSUM_W-1] ? WSUM_W'(-wy_in) : wy_in;
	assign den = {1'b0, area_mag} + {area_mag, 1'b0};

	pca_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_x (
		.clk   (clk),
		.start (pop),
		.step  (step),
		.num   (NUM_W'(wx_mag) << FRAC_BITS),
		.den   (den),
		.quot  (qx)
	);

	pca_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_y (
		.clk   (clk),
		.start (pop),
		.step  (step),
		.num   (NUM_W'(wy_mag) << FRAC_BITS),
		.den   (den),
		.quot  (qy)
	);

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		step = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			pca_pkg::BK_IDLE: begin
				if (!fifo_stat.empty) begin
					pop = 1'b1;
					state_d = pca_pkg::BK_RUN;
				end
			end
			pca_pkg::BK_RUN: begin
				step = 1'b1;
				if (step_q == STEP_W'(QB - 1)) begin
					state_d = pca_pkg::BK_DONE;
				end
			end
			pca_pkg::BK_DONE: begin
				if (!res_valid_q || result.ready) begin
					load_out = 1'b1;
					state_d = pca_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = pca_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pca_pkg::BK_IDLE;
			step_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				step_q <= '0;
			end else if (step) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			area_q <= area_in;
			negx_q <= wx_in[WSUM_W-1] ^ area_in[AREA_W-1];
			negy_q <= wy_in[WSUM_W-1] ^ area_in[AREA_W-1];
			degen_q <= (area_in == '0);
			ovf_q <= ovf_in;
			midx_q <= mid_fix(sx_in);
			midy_q <= mid_fix(sy_in);
		end
	end

	assign area_ext = 64'(area_q);

	always_ff @(posedge clk) begin
		if (load_out) begin
			cx_q <= degen_q ? midx_q : quot_fix(qx, negx_q);
			cy_q <= degen_q ? midy_q : quot_fix(qy, negy_q);
			da_q <= area_ext[pca_pkg::AREA_OUT_BITS-1:0];
			degen_out_q <= degen_q;
			ovf_out_q <= ovf_q;
		end
	end

	assign result.valid = res_valid_q;
	assign result.centroid_x = cx_q;
	assign result.centroid_y = cy_q;
	assign result.doubled_area = da_q;
	assign result.degenerate = degen_out_q;
	assign result.too_many_vertices = ovf_out_q;

`ifndef SYNTH
	a_result_after_divide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == pca_pkg::BK_DONE))
		else $error("result raised outside the finishing state");

	a_all_steps_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pca_pkg::BK_DONE) |-> (step_q == STEP_W'(QB)))
		else $error("divider finished with a wrong number of steps");
`endif

endmodule

`default_nettype wire
